FILE: design/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable priority queue package
// Shared types, codes and constants for the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  // field widths
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned LIMIT_W = 5;

  // default depth of the cell row and reset value of the limit register
  localparam int unsigned CAPACITY_DEF = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // configuration register addresses
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY_LIMIT = 3'd0;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2
  } spq_cmd_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } spq_status_e;

  // one stored item
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_item_t;

  // broadcast control to every cell
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } spq_ctrl_t;

endpackage
`default_nettype wire

FILE: design/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable priority queue cell
// One slot of the sorted row: keeps its item, takes the new item, takes the
// item of its left neighbour on insertion or of its right one on removal.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire spq_ctrl_t ctrl_i,
  input  wire spq_item_t left_item_i,
  input  wire logic      left_keep_i,
  input  wire spq_item_t right_item_i,
  output      spq_item_t item_o,
  output      logic      keep_o
);

  logic              valid_q;
  logic [PRIO_W-1:0] prio_q;
  logic [DATA_W-1:0] data_q;
  spq_item_t         item_q, item_d;

  assign item_q = '{valid: valid_q, prio: prio_q, data: data_q};

  // item stays in place on insertion when it ranks at or before the new one
  assign keep_o = item_q.valid && (item_q.prio <= ctrl_i.prio);

  // next slot content
  always_comb begin
    item_d = item_q;
    if (ctrl_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          item_d = '{valid: 1'b1, prio: ctrl_i.prio, data: ctrl_i.data};
        end else begin
          item_d = left_item_i;
        end
      end
    end else if (ctrl_i.deq) begin
      item_d = right_item_i;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= item_d.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    prio_q <= item_d.prio;
    data_q <= item_d.data;
  end

  assign item_o = item_q;

endmodule
`default_nettype wire

FILE: design/stable_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable priority queue unit
// Bounded priority queue with arrival order kept among equal priorities.
// ----------------------------------------------------------------------------
// Takes one command per clock cycle (enqueue, dequeue or peek) and returns
// one result for each, registered, in the cycle after the transaction. The
// items sit in a row of CAPACITY cells sorted by priority, head in cell 0;
// every cell compares its own priority with the broadcast one in parallel and
// all cells shift together, so one compare plus the broadcast fan-out sets the
// cycle time, not the length of the row and not the rate.
// A new command is taken while the previous result waits, as long as the
// output register is free or is being read in the same cycle. The limit
// register (address 0) may only be written while the queue is idle.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [CMD_W-1:0]   command_i,
  input  wire logic [DATA_W-1:0]  in_data_i,
  input  wire logic [PRIO_W-1:0]  in_priority_i,
  // result channel
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [STAT_W-1:0]  status_o,
  output      logic [PRIO_W-1:0]  out_priority_o,
  output      logic [DATA_W-1:0]  out_data_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [PRIO_W-1:0]  oprio_q, oprio_d;
  logic [DATA_W-1:0]  odata_q, odata_d;
  logic               accept;
  logic               full;
  logic               empty;
  spq_ctrl_t          ctrl;

  spq_item_t cell_item [CAPACITY];
  spq_item_t left_item [CAPACITY];
  spq_item_t right_item[CAPACITY];
  logic      cell_keep [CAPACITY];
  logic      left_keep [CAPACITY];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY_LIMIT) ? {{(32-LIMIT_W){1'b0}}, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // fill state
  assign full  = (CMP_W'(count_q) >= CMP_W'(limit_q)) || (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // command decode and result
  always_comb begin
    ctrl      = '{enq: 1'b0, deq: 1'b0, prio: in_priority_i, data: in_data_i};
    count_d   = count_q;
    status_d  = ST_OK;
    oprio_d   = '0;
    odata_d   = '0;
    case (command_i)
      CMD_ENQUEUE: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          ctrl.enq = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      CMD_DEQUEUE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          oprio_d  = cell_item[0].prio;
          odata_d  = cell_item[0].data;
          ctrl.deq = accept;
          count_d  = count_q - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          oprio_d = cell_item[0].prio;
          odata_d = cell_item[0].data;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // item count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      oprio_q  <= oprio_d;
      odata_q  <= odata_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = oprio_q;
  assign out_data_o     = odata_q;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_item[i] = '0;
      assign left_keep[i] = 1'b1;
    end else begin : g_mid
      assign left_item[i] = cell_item[i-1];
      assign left_keep[i] = cell_keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_item[i] = '0;
    end else begin : g_inner
      assign right_item[i] = cell_item[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_item_i  (left_item[i]),
      .left_keep_i  (left_keep[i]),
      .right_item_i (right_item[i]),
      .item_o       (cell_item[i]),
      .keep_o       (cell_keep[i])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("item count above capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_item[0].valid == (count_q != '0))
    else $error("head cell valid does not match item count");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_item[0].valid && cell_item[1].valid) |-> (cell_item[0].prio <= cell_item[1].prio))
    else $error("head cells out of priority order");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_DEQUEUE) && !empty) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("dequeue did not lower the item count");

endmodule
`default_nettype wire

FILE: tb/stable_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable priority queue unit testbench
// Drives enqueue, dequeue, peek and unknown commands through the valid/ready
// command channel, predicts each result with a behavioural copy of the sorted
// cell row, and checks every result transaction field by field. The capacity
// limit is rewritten between phases over the APB port and read back.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned ROW_DEPTH = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // expected content of one result transaction
  typedef struct {
    spq_status_e       status;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } queue_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // command channel
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [CMD_W-1:0]  command_i     = '0;
  logic [DATA_W-1:0] in_data_i     = '0;
  logic [PRIO_W-1:0] in_priority_i = '0;

  // result channel
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [PRIO_W-1:0] out_priority_o;
  logic [DATA_W-1:0] out_data_o;

  // configuration port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predicted row of cells, head at index 0
  logic [PRIO_W-1:0]  row_prio [ROW_DEPTH];
  logic [DATA_W-1:0]  row_data [ROW_DEPTH];
  int unsigned        row_count = 0;
  logic [LIMIT_W-1:0] row_limit = LIMIT_RESET;

  queue_result_t pending_results[$];

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned stall_left   = 0;
  bit          idle_off     = 1'b0;

  // coverage tallies for the summary
  int unsigned n_commands  = 0;
  int unsigned n_stored    = 0;
  int unsigned n_overflow  = 0;
  int unsigned n_empty     = 0;
  int unsigned n_served    = 0;
  int unsigned peak_depth  = 0;

  always #2 clk_i = ~clk_i;

  stable_priority_queue_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .in_data_i      (in_data_i),
    .in_priority_i  (in_priority_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_data_o     (out_data_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // behavioural row: work out one result and update the predicted cells
  function automatic queue_result_t serve_command(logic [CMD_W-1:0] cmd,
                                                  logic [DATA_W-1:0] data,
                                                  logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int unsigned   lim;
    int unsigned   pos;
    res.status = ST_OK;
    res.prio   = '0;
    res.data   = '0;
    lim = (row_limit > ROW_DEPTH) ? ROW_DEPTH : row_limit;
    case (cmd)
      CMD_ENQUEUE: begin
        if (row_count >= lim) begin
          res.status = ST_OVERFLOW;
        end else begin
          // new item goes behind every item of equal or better priority
          pos = 0;
          while (pos < row_count && row_prio[pos] <= prio) pos++;
          for (int unsigned i = row_count; i > pos; i--) begin
            row_prio[i] = row_prio[i-1];
            row_data[i] = row_data[i-1];
          end
          row_prio[pos] = prio;
          row_data[pos] = data;
          row_count++;
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (row_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.prio = row_prio[0];
          res.data = row_data[0];
          if (cmd == CMD_DEQUEUE) begin
            for (int unsigned i = 0; i + 1 < row_count; i++) begin
              row_prio[i] = row_prio[i+1];
              row_data[i] = row_data[i+1];
            end
            row_count--;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
  endtask

  // gap before a transaction: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (idle_off) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("stable_priority_queue_unit_tb NOT OK");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    int unsigned roll;
    if (idle_off) begin
      out_ready_i <= 1'b1;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 20) stall_left <= $urandom_range(1, 3);
      else if (roll < 23) stall_left <= $urandom_range(10, 30);
    end
  end

  // check each result transaction, then predict for each command transaction
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result status", '0, 32'(status_o));
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            note_mismatch("status", 32'(want.status), 32'(status_o));
          if (out_priority_o !== want.prio) note_mismatch("out_priority", 32'(want.prio),
                                                          32'(out_priority_o));
          if (out_data_o !== want.data) note_mismatch("out_data", want.data, out_data_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = serve_command(command_i, in_data_i, in_priority_i);
        pending_results.push_back(want);
        n_commands++;
        if (want.status == ST_OVERFLOW) n_overflow++;
        else if (want.status == ST_EMPTY) n_empty++;
        else if (command_i == CMD_ENQUEUE) n_stored++;
        else if (command_i != CMD_UNKNOWN) n_served++;
        if (row_count > peak_depth) peak_depth = row_count;
      end
    end
  end

  // one command transaction; entered and left at a falling edge
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                              logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i    <= 1'b0;
      command_i     <= CMD_W'($urandom_range(0, 3));
      in_data_i     <= $urandom;
      in_priority_i <= PRIO_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    in_data_i     <= data;
    in_priority_i <= prio;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic cfg_read(logic [PADDR_W-1:0] addr, output logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the limit with random upper bits, then read it back
  task automatic set_limit(logic [LIMIT_W-1:0] limit);
    logic [31:0] word;
    logic [31:0] readback;
    word = $urandom;
    word[LIMIT_W-1:0] = limit;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_CAPACITY_LIMIT;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    row_limit = word[LIMIT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    cfg_read(ADDR_CAPACITY_LIMIT, readback);
    if (readback !== 32'(limit)) note_mismatch("capacity_limit readback", 32'(limit), readback);
  endtask

  // empty queue, reset value of the limit, unknown command
  task automatic test_reset_state();
    logic [31:0] readback;
    cfg_read(ADDR_CAPACITY_LIMIT, readback);
    if (readback !== 32'(LIMIT_RESET))
      note_mismatch("capacity_limit after reset", 32'(LIMIT_RESET), readback);
    send_command(CMD_PEEK, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(CMD_DEQUEUE, 32'h0, 16'h0);
    send_command(CMD_UNKNOWN, 32'hA5A5_5A5A, 16'h1234);
    wait_idle();
  endtask

  // extreme values and equal priorities leaving in arrival order
  task automatic test_extremes_and_ties();
    send_command(CMD_ENQUEUE, 32'h8000_0000, 16'hFFFF);
    send_command(CMD_ENQUEUE, 32'h7FFF_FFFF, 16'h0000);
    send_command(CMD_ENQUEUE, 32'h0000_0000, 16'h0000);
    send_command(CMD_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(CMD_UNKNOWN, 32'hDEAD_0001, 16'h0001);
    send_command(CMD_PEEK, 32'h0, 16'h0);
    repeat (4) send_command(CMD_DEQUEUE, $urandom, PRIO_W'($urandom));
    send_command(CMD_DEQUEUE, 32'h0, 16'h0);
    wait_idle();
  endtask

  // limit of one, limit of zero, limit lowered below the stored count
  task automatic test_limit_edges();
    set_limit(5'd1);
    send_command(CMD_ENQUEUE, 32'h1111_1111, 16'h0010);
    send_command(CMD_ENQUEUE, 32'h2222_2222, 16'h0001);
    send_command(CMD_DEQUEUE, 32'h0, 16'h0);
    wait_idle();
    set_limit(5'd0);
    send_command(CMD_ENQUEUE, 32'h3333_3333, 16'h0000);
    send_command(CMD_PEEK, 32'h0, 16'h0);
    wait_idle();
    set_limit(5'd16);
    repeat (3) send_command(CMD_ENQUEUE, $urandom, PRIO_W'($urandom_range(0, 3)));
    wait_idle();
    set_limit(5'd2);
    send_command(CMD_ENQUEUE, $urandom, 16'h0000);
    send_command(CMD_DEQUEUE, 32'h0, 16'h0);
    send_command(CMD_ENQUEUE, $urandom, 16'h0000);
    send_command(CMD_DEQUEUE, 32'h0, 16'h0);
    send_command(CMD_ENQUEUE, $urandom, 16'h0002);
    repeat (3) send_command(CMD_DEQUEUE, 32'h0, 16'h0);
    wait_idle();
  endtask

  // priority pool weighted towards ties and the extremes
  function automatic logic [PRIO_W-1:0] pick_priority();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return PRIO_W'($urandom_range(0, 7));
    if (roll < 80) return PRIO_W'($urandom);
    if (roll < 90) return '0;
    return '1;
  endfunction

  // one random phase under a fixed limit: alternating fill and drain bursts
  task automatic run_phase(logic [LIMIT_W-1:0] limit, int unsigned n_items,
                           bit quiet, bit pause_midway);
    int unsigned      roll;
    int unsigned      enq_share;
    logic [CMD_W-1:0] cmd;
    set_limit(limit);
    idle_off = quiet;
    enq_share = 70;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 20 == 0) enq_share = ($urandom_range(0, 1) != 0) ? 75 : 25;
      if (pause_midway && k == n_items / 2) wait_idle();
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = CMD_UNKNOWN;
      else if (roll < enq_share) cmd = CMD_ENQUEUE;
      else if (roll < enq_share + (100 - enq_share) * 2 / 3) cmd = CMD_DEQUEUE;
      else cmd = CMD_PEEK;
      send_command(cmd, $urandom, pick_priority());
    end
    wait_idle();
    idle_off = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(5'd16, 200, 1'b0, 1'b0);
    run_phase(5'd31, 200, 1'b0, 1'b1);
    run_phase(5'd3,  120, 1'b0, 1'b0);
    run_phase(5'd0,   30, 1'b0, 1'b0);
    run_phase(5'd1,   80, 1'b0, 1'b0);
    run_phase(5'd8,  150, 1'b0, 1'b0);
    run_phase(5'd16, 200, 1'b1, 1'b0);
    run_phase(5'd12, 170, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_extremes_and_ties();
    test_limit_edges();
    test_random_traffic();

    // settle, then look for anything left behind
    in_valid_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_mismatch("results never returned", 0, pending_results.size());

    $display("run covered %0d commands: %0d stored, %0d served, %0d overflows, %0d empty",
             n_commands, n_stored, n_served, n_overflow, n_empty);
    $display("limits from 0 to 31 applied, deepest row %0d of %0d, %0d mismatches",
             peak_depth, ROW_DEPTH, error_count);
    if (error_count == 0) begin
      $display("stable_priority_queue_unit_tb OK");
    end else begin
      $display("stable_priority_queue_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_unit.sv
tb/stable_priority_queue_unit_tb.sv
